// ----- hw/rtl/weq_pkg.sv -----
// ----------------------------------------------------------------------------
// weq_pkg
// Shared types, field layout, register indexes and saturation helper for the
// 2D wave equation grid block.
// ----------------------------------------------------------------------------
package weq_pkg;

    // Field widths
    localparam int FUNC_W    = 2;
    localparam int HGT_W     = 16;
    localparam int COEF_W    = 16;
    localparam int TSTEP_W   = 16;
    localparam int ELAPSED_W = 16;
    localparam int DIM_W     = 8;
    localparam int ACCUM_W   = 17;
    localparam int ROW_W     = 7;
    localparam int COL_W     = 7;
    localparam int MAG_W     = 16;

    // Configuration port
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Stream layout
    localparam int S_DATA_W    = 48;
    localparam int ELAPSED_LSB = 0;
    localparam int ROW_LSB     = ELAPSED_LSB + ELAPSED_W;
    localparam int COL_LSB     = ROW_LSB + ROW_W;
    localparam int MAG_LSB     = COL_LSB + COL_W;
    localparam int M_DATA_W    = 16;
    localparam int M_USER_W    = 2;
    localparam int STEPPED_BIT = 0;
    localparam int STATUS_BIT  = 1;

    // Update datapath widths
    localparam int NSUM_W  = HGT_W + 2;
    localparam int PCUR_W  = COEF_W + HGT_W;
    localparam int PNB_W   = COEF_W + NSUM_W;
    localparam int SUM_W   = PNB_W + 2;
    localparam int FRAC_W  = 14;
    localparam int RND_W   = SUM_W - FRAC_W;

    localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(8192);
    localparam logic signed [RND_W-1:0] RND_HMAX = RND_W'(32767);
    localparam logic signed [RND_W-1:0] RND_HMIN = RND_W'(-32768);

    localparam logic [DIM_W-1:0] MIN_DIM = DIM_W'(3);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COEF_PREV   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COEF_NB     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COLS        = 3'd5;

    // Reset values
    localparam logic signed [COEF_W-1:0] COEF_PREV_RST   = -16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_CENTER_RST = 16'sd16384;
    localparam logic signed [COEF_W-1:0] COEF_NB_RST     = 16'sd4096;
    localparam logic [TSTEP_W-1:0]       TIME_STEP_RST   = 16'd1000;
    localparam logic [DIM_W-1:0]         DIM_RST         = 8'd128;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADVANCE = 2'd0,
        FUNC_DISTURB = 2'd1,
        FUNC_READ    = 2'd2
    } func_t;

    typedef logic signed [HGT_W-1:0] height_t;

    function automatic height_t sat_height(input logic signed [RND_W-1:0] v);
        height_t h;
        if (v > RND_HMAX) begin
            h = 16'sh7FFF;
        end
        else if (v < RND_HMIN) begin
            h = 16'sh8000;
        end
        else begin
            h = v[HGT_W-1:0];
        end
        return h;
    endfunction

endpackage

// ----- hw/rtl/wave_equation_grid_step.sv -----
// ----------------------------------------------------------------------------
// wave_equation_grid_step
// Fixed-point 2D wave equation on two height grids held in block memories.
// ----------------------------------------------------------------------------
// After reset the block sweeps both grid memories to zero, one address a
// cycle over all MAX_ROWS*MAX_COLS addresses, and takes no request until that
// is done; configuration writes are taken at any time. A request is then
// taken only while the sequencer is idle, and its result goes to an output
// register so the next request can be taken while the result waits. A
// disturb is a read-modify-write of five cells through one port. An advance
// that updates the grid needs three reads of the current grid for each
// interior cell (up, down, right), and the current grid has two read ports,
// so each cell is issued across states S_UC0 and S_UC1, plus a priming
// state S_UPR at the head of each row.
// ----------------------------------------------------------------------------
module wave_equation_grid_step
    import weq_pkg::*;
#(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // elapsed, row, col, magnitude, pad
    input  logic [FUNC_W-1:0]     s_tuser,   // func
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // height
    output logic [M_USER_W-1:0]   m_tuser    // stepped, status
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int R_W    = $clog2(MAX_ROWS);
    localparam int C_W    = $clog2(MAX_COLS);

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_RD    = 11'b000_0000_0100,
        S_RDW   = 11'b000_0000_1000,
        S_DRD   = 11'b000_0001_0000,
        S_DWR   = 11'b000_0010_0000,
        S_UPR   = 11'b000_0100_0000,
        S_UC0   = 11'b000_1000_0000,
        S_UC1   = 11'b001_0000_0000,
        S_UDRN  = 11'b010_0000_0000,
        S_DONE  = 11'b100_0000_0000
    } state_t;

    // tag of the read issued in the previous cycle during an update
    typedef enum logic [1:0] {
        ISS_NONE  = 2'd0,
        ISS_PRIME = 2'd1,
        ISS_C0    = 2'd2,
        ISS_C1    = 2'd3
    } iss_t;

    localparam logic [2:0] TGT_CENTER = 3'd0;
    localparam logic [2:0] TGT_RIGHT  = 3'd1;
    localparam logic [2:0] TGT_LEFT   = 3'd2;
    localparam logic [2:0] TGT_DOWN   = 3'd3;
    localparam logic [2:0] TGT_UP     = 3'd4;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [R_W-1:0] r,
                                                   input logic [C_W-1:0] c);
        return ADDR_W'(r) * ADDR_W'(MAX_COLS) + ADDR_W'(c);
    endfunction

    // Configuration registers
    logic signed [COEF_W-1:0] coef_prev_reg;
    logic signed [COEF_W-1:0] coef_center_reg;
    logic signed [COEF_W-1:0] coef_nb_reg;
    logic [TSTEP_W-1:0]       time_step_reg;
    logic [DIM_W-1:0]         rows_in_use_reg;
    logic [DIM_W-1:0]         cols_in_use_reg;

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic [ACCUM_W-1:0]  accum_reg, accum_next;
    logic                sel_reg, sel_next;
    logic [R_W-1:0]      r_reg, r_next;
    logic [C_W-1:0]      c_reg, c_next;
    logic [2:0]          k_reg, k_next;
    iss_t                iss_reg, iss_next;
    logic                a_vld_reg, b_vld_reg;
    logic                m_tvalid_reg, m_tvalid_next;

    // Payload state
    logic [R_W-1:0]      op_row_reg, op_row_next;
    logic [C_W-1:0]      op_col_reg, op_col_next;
    height_t             op_mag_reg, op_mag_next;
    height_t             res_height_reg, res_height_next;
    logic                res_stepped_reg, res_stepped_next;
    logic                res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   iss_addr_reg, iss_addr_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [M_USER_W-1:0] m_tuser_reg, m_tuser_next;

    // Update window and pipeline
    height_t                   left_reg, ctr_reg, up_reg, dn_reg, prv_reg;
    logic signed [NSUM_W-1:0]  nsum_reg;
    height_t                   cv_reg, pv_reg;
    logic [ADDR_W-1:0]         wa_a_reg, wa_b_reg;
    logic signed [PCUR_W-1:0]  p_prev_reg, p_ctr_reg;
    logic signed [PNB_W-1:0]   p_nb_reg;

    // Grid memories
    height_t           grid_a_mem [DEPTH];
    height_t           grid_b_mem [DEPTH];
    height_t           a_q0_reg, a_q1_reg, b_q0_reg, b_q1_reg;
    logic [ADDR_W-1:0] a_ra0, a_ra1, a_wa, b_ra0, b_ra1, b_wa;
    logic              a_we, b_we;
    height_t           a_wd, b_wd;

    // Logical ports
    logic [ADDR_W-1:0] cur_ra0, cur_ra1, old_ra, cur_wa;
    logic              cur_we, old_we, clr;
    height_t           cur_wd, old_wd, cur_q0, cur_q1, old_q0;

    // Request fields
    func_t                 in_func;
    logic [ELAPSED_W-1:0]  in_elapsed;
    logic [ROW_W-1:0]      in_row;
    logic [COL_W-1:0]      in_col;
    height_t               in_mag;

    logic [DIM_W-1:0]      rows_use, cols_use;
    logic [ACCUM_W-1:0]    accum_sum;
    logic                  dist_ok, read_ok, c_end, r_end, out_free;

    logic [R_W-1:0]        tgt_r;
    logic [C_W-1:0]        tgt_c;
    height_t               tgt_add, mag_half;
    logic [ADDR_W-1:0]     tgt_addr;

    logic signed [SUM_W-1:0] sum_c, sum_rnd;

    assign in_func    = func_t'(s_tuser);
    assign in_elapsed = s_tdata[ELAPSED_LSB +: ELAPSED_W];
    assign in_row     = s_tdata[ROW_LSB +: ROW_W];
    assign in_col     = s_tdata[COL_LSB +: COL_W];
    assign in_mag     = s_tdata[MAG_LSB +: MAG_W];

    // Clamp grid size to the storage, with MIN_DIM as the floor
    always_comb
    begin
        if (rows_in_use_reg < MIN_DIM) begin
            rows_use = MIN_DIM;
        end
        else if (32'(rows_in_use_reg) > MAX_ROWS) begin
            rows_use = DIM_W'(MAX_ROWS);
        end
        else begin
            rows_use = rows_in_use_reg;
        end
        if (cols_in_use_reg < MIN_DIM) begin
            cols_use = MIN_DIM;
        end
        else if (32'(cols_in_use_reg) > MAX_COLS) begin
            cols_use = DIM_W'(MAX_COLS);
        end
        else begin
            cols_use = cols_in_use_reg;
        end
    end

    assign accum_sum = accum_reg + ACCUM_W'(in_elapsed);
    assign dist_ok   = (in_row > ROW_W'(1)) && (in_col > COL_W'(1))
                       && ((9'(in_row) + 9'd2) < 9'(rows_use))
                       && ((9'(in_col) + 9'd2) < 9'(cols_use));
    assign read_ok   = (9'(in_row) < 9'(rows_use)) && (9'(in_col) < 9'(cols_use));
    assign c_end     = (32'(c_reg) == 32'(cols_use) - 32'd2);
    assign r_end     = (32'(r_reg) == 32'(rows_use) - 32'd2);
    assign out_free  = !m_tvalid_reg || m_tready;

    // Disturb targets: center gets the full magnitude, neighbors half
    assign mag_half = op_mag_reg >>> 1;
    always_comb
    begin
        tgt_r   = op_row_reg;
        tgt_c   = op_col_reg;
        tgt_add = mag_half;
        case (k_reg)
            TGT_CENTER: tgt_add = op_mag_reg;
            TGT_RIGHT:  tgt_c   = op_col_reg + C_W'(1);
            TGT_LEFT:   tgt_c   = op_col_reg - C_W'(1);
            TGT_DOWN:   tgt_r   = op_row_reg + R_W'(1);
            TGT_UP:     tgt_r   = op_row_reg - R_W'(1);
            default:    tgt_add = op_mag_reg;
        endcase
    end
    assign tgt_addr = cell_addr(tgt_r, tgt_c);
    assign cur_wa   = tgt_addr;
    assign cur_wd   = sat_height(RND_W'(cur_q0) + RND_W'(tgt_add));

    // Last pipeline stage: sum, round half up, saturate, write back
    assign sum_c   = SUM_W'(p_prev_reg) + SUM_W'(p_ctr_reg) + SUM_W'(p_nb_reg);
    assign sum_rnd = (sum_c + RND_HALF) >>> FRAC_W;
    assign old_we  = b_vld_reg;
    assign old_wd  = sat_height(sum_rnd[RND_W-1:0]);

    assign clr = (state_reg == S_CLEAR);

    always_comb
    begin
        state_next       = state_reg;
        clr_cnt_next     = clr_cnt_reg;
        accum_next       = accum_reg;
        sel_next         = sel_reg;
        r_next           = r_reg;
        c_next           = c_reg;
        k_next           = k_reg;
        iss_next         = ISS_NONE;
        iss_addr_next    = iss_addr_reg;
        op_row_next      = op_row_reg;
        op_col_next      = op_col_reg;
        op_mag_next      = op_mag_reg;
        res_height_next  = res_height_reg;
        res_stepped_next = res_stepped_reg;
        res_status_next  = res_status_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        cur_ra0          = tgt_addr;
        cur_ra1          = tgt_addr;
        old_ra           = cell_addr(r_reg, c_reg);
        cur_we           = 1'b0;
        s_tready         = 1'b0;

        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    op_row_next      = R_W'(in_row);
                    op_col_next      = C_W'(in_col);
                    op_mag_next      = in_mag;
                    res_height_next  = '0;
                    res_stepped_next = 1'b0;
                    res_status_next  = 1'b0;
                    k_next           = TGT_CENTER;
                    state_next       = S_DONE;
                    case (in_func)
                        FUNC_ADVANCE:
                        begin
                            if (accum_sum >= ACCUM_W'(time_step_reg)) begin
                                accum_next = '0;
                                r_next     = R_W'(1);
                                state_next = S_UPR;
                            end
                            else begin
                                accum_next = accum_sum;
                            end
                        end
                        FUNC_DISTURB:
                        begin
                            if (dist_ok) begin
                                state_next = S_DRD;
                            end
                            else begin
                                res_status_next = 1'b1;
                            end
                        end
                        FUNC_READ:
                        begin
                            if (read_ok) begin
                                state_next = S_RD;
                            end
                            else begin
                                res_status_next = 1'b1;
                            end
                        end
                        default: res_status_next = 1'b1;
                    endcase
                end
            end
            S_RD:
            begin
                cur_ra0    = cell_addr(op_row_reg, op_col_reg);
                state_next = S_RDW;
            end
            S_RDW:
            begin
                res_height_next = cur_q0;
                state_next      = S_DONE;
            end
            S_DRD:
            begin
                state_next = S_DWR;
            end
            S_DWR:
            begin
                cur_we = 1'b1;
                k_next = k_reg + 3'd1;
                if (k_reg == TGT_UP) begin
                    state_next = S_DONE;
                end
                else begin
                    state_next = S_DRD;
                end
            end
            S_UPR:
            begin
                cur_ra0    = cell_addr(r_reg, '0);
                cur_ra1    = cell_addr(r_reg, C_W'(1));
                iss_next   = ISS_PRIME;
                c_next     = C_W'(1);
                state_next = S_UC0;
            end
            S_UC0:
            begin
                cur_ra0    = cell_addr(r_reg - R_W'(1), c_reg);
                cur_ra1    = cell_addr(r_reg + R_W'(1), c_reg);
                iss_next   = ISS_C0;
                state_next = S_UC1;
            end
            S_UC1:
            begin
                cur_ra0       = cell_addr(r_reg, c_reg + C_W'(1));
                iss_next      = ISS_C1;
                iss_addr_next = cell_addr(r_reg, c_reg);
                if (!c_end) begin
                    c_next     = c_reg + C_W'(1);
                    state_next = S_UC0;
                end
                else if (!r_end) begin
                    r_next     = r_reg + R_W'(1);
                    state_next = S_UPR;
                end
                else begin
                    state_next = S_UDRN;
                end
            end
            S_UDRN:
            begin
                // wait until the last cell is written, then swap roles
                if (iss_reg == ISS_NONE && !a_vld_reg && !b_vld_reg) begin
                    sel_next         = !sel_reg;
                    res_stepped_next = 1'b1;
                    state_next       = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free) begin
                    m_tvalid_next            = 1'b1;
                    m_tdata_next             = res_height_reg;
                    m_tuser_next[STEPPED_BIT] = res_stepped_reg;
                    m_tuser_next[STATUS_BIT]  = res_status_reg;
                    state_next               = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Map current/old roles onto the two physical banks
    assign cur_q0 = sel_reg ? b_q0_reg : a_q0_reg;
    assign cur_q1 = sel_reg ? b_q1_reg : a_q1_reg;
    assign old_q0 = sel_reg ? a_q0_reg : b_q0_reg;

    assign a_ra0 = sel_reg ? old_ra : cur_ra0;
    assign a_ra1 = cur_ra1;
    assign a_we  = clr || (sel_reg ? old_we : cur_we);
    assign a_wa  = clr ? clr_cnt_reg : (sel_reg ? wa_b_reg : cur_wa);
    assign a_wd  = clr ? '0 : (sel_reg ? old_wd : cur_wd);

    assign b_ra0 = sel_reg ? cur_ra0 : old_ra;
    assign b_ra1 = cur_ra1;
    assign b_we  = clr || (sel_reg ? cur_we : old_we);
    assign b_wa  = clr ? clr_cnt_reg : (sel_reg ? cur_wa : wa_b_reg);
    assign b_wd  = clr ? '0 : (sel_reg ? cur_wd : old_wd);

    always_ff @(posedge clk)
    begin
        if (a_we) begin
            grid_a_mem[a_wa] <= a_wd;
        end
        a_q0_reg <= grid_a_mem[a_ra0];
        a_q1_reg <= grid_a_mem[a_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (b_we) begin
            grid_b_mem[b_wa] <= b_wd;
        end
        b_q0_reg <= grid_b_mem[b_ra0];
        b_q1_reg <= grid_b_mem[b_ra1];
    end

    // Configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            coef_prev_reg   <= COEF_PREV_RST;
            coef_center_reg <= COEF_CENTER_RST;
            coef_nb_reg     <= COEF_NB_RST;
            time_step_reg   <= TIME_STEP_RST;
            rows_in_use_reg <= DIM_RST;
            cols_in_use_reg <= DIM_RST;
        end
        else if (cfg_we) begin
            case (cfg_index)
                REG_COEF_PREV:   coef_prev_reg   <= cfg_data;
                REG_COEF_CENTER: coef_center_reg <= cfg_data;
                REG_COEF_NB:     coef_nb_reg     <= cfg_data;
                REG_TIME_STEP:   time_step_reg   <= cfg_data;
                REG_ROWS:        rows_in_use_reg <= cfg_data[DIM_W-1:0];
                REG_COLS:        cols_in_use_reg <= cfg_data[DIM_W-1:0];
                default:         ;
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            accum_reg    <= '0;
            sel_reg      <= 1'b0;
            r_reg        <= '0;
            c_reg        <= '0;
            k_reg        <= TGT_CENTER;
            iss_reg      <= ISS_NONE;
            a_vld_reg    <= 1'b0;
            b_vld_reg    <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            accum_reg    <= accum_next;
            sel_reg      <= sel_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            k_reg        <= k_next;
            iss_reg      <= iss_next;
            a_vld_reg    <= (iss_reg == ISS_C1);
            b_vld_reg    <= a_vld_reg;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_row_reg      <= op_row_next;
        op_col_reg      <= op_col_next;
        op_mag_reg      <= op_mag_next;
        res_height_reg  <= res_height_next;
        res_stepped_reg <= res_stepped_next;
        res_status_reg  <= res_status_next;
        iss_addr_reg    <= iss_addr_next;
        m_tdata_reg     <= m_tdata_next;
        m_tuser_reg     <= m_tuser_next;

        // capture returned reads; slide the row window on each cell
        case (iss_reg)
            ISS_PRIME:
            begin
                left_reg <= cur_q0;
                ctr_reg  <= cur_q1;
            end
            ISS_C0:
            begin
                up_reg  <= cur_q0;
                dn_reg  <= cur_q1;
                prv_reg <= old_q0;
            end
            ISS_C1:
            begin
                nsum_reg <= NSUM_W'(up_reg) + NSUM_W'(dn_reg)
                            + NSUM_W'(left_reg) + NSUM_W'(cur_q0);
                cv_reg   <= ctr_reg;
                pv_reg   <= prv_reg;
                wa_a_reg <= iss_addr_reg;
                left_reg <= ctr_reg;
                ctr_reg  <= cur_q0;
            end
            default: ;
        endcase

        p_prev_reg <= coef_prev_reg * pv_reg;
        p_ctr_reg  <= coef_center_reg * cv_reg;
        p_nb_reg   <= coef_nb_reg * nsum_reg;
        wa_b_reg   <= wa_a_reg;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule
